FILE: design/gtia_pkg.sv
// Shared types, codes and sizes for the generational task id allocator.
package gtia_pkg;

    // Descriptor slots; the slot index is the id modulo this value (power of two)
    localparam int NUM_SLOTS = 64;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int ID_W      = 31;
    localparam int TASK_W    = 32;

    // Request action codes
    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_GET   = 2'd2;
    localparam logic [1:0] ACT_RSVD  = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_INVALID   = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // Free list update from the compute stage
    typedef struct packed {
        logic            pop;
        logic            push;
        logic [ID_W-1:0] push_id;
    } gtia_fl_ctrl_t;

    // Free list status toward the compute stage
    typedef struct packed {
        logic            empty;
        logic            full;
        logic [ID_W-1:0] pop_id;
    } gtia_fl_stat_t;

    // Slot table write from the compute stage
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   id;
    } gtia_slot_wr_t;

endpackage

FILE: design/gtia_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gtia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/gtia_free_list.sv
// FIFO free list of task ids: head/tail/count, id RAM, fill count and write bypass.
module gtia_free_list (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   rd_issue,
    input  gtia_pkg::gtia_fl_ctrl_t ctrl,
    output gtia_pkg::gtia_fl_stat_t stat
);
    import gtia_pkg::*;

    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              byp_reg, byp_next;
    logic [ID_W-1:0]   byp_data_reg, byp_data_next;
    logic              init_reg, init_next;
    logic [ID_W-1:0]   ram_q;

    // Pointer and count update
    always_comb
    begin
        head_next  = ctrl.pop  ? head_reg + 1'b1 : head_reg;
        tail_next  = ctrl.push ? tail_reg + 1'b1 : tail_reg;
        count_next = count_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - 1'b1;
        end
        // entries are written in tail order, so fill tracks which hold real data
        fill_next = fill_reg;
        if (ctrl.push && (fill_reg != CNT_W'(NUM_SLOTS)))
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    // Read side: bypass of a same-cycle write, and reset contents for unwritten entries
    always_comb
    begin
        byp_next      = byp_reg;
        byp_data_next = byp_data_reg;
        init_next     = init_reg;
        if (rd_issue)
        begin
            byp_next      = ctrl.push && (tail_reg == head_next);
            byp_data_next = ctrl.push_id;
            init_next     = !({1'b0, head_next} < fill_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= CNT_W'(NUM_SLOTS);
            fill_reg  <= '0;
            byp_reg   <= 1'b0;
            init_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            fill_reg  <= fill_next;
            byp_reg   <= byp_next;
            init_reg  <= init_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= byp_data_next;
    end

    gtia_ram #(
        .WIDTH (ID_W),
        .DEPTH (NUM_SLOTS)
    ) u_id_ram (
        .clk   (clk),
        .we    (ctrl.push),
        .waddr (tail_reg),
        .wdata (ctrl.push_id),
        .re    (rd_issue),
        .raddr (head_next),
        .rdata (ram_q)
    );

    // Status toward the compute stage; an unwritten entry holds its own index
    always_comb
    begin
        stat.empty = (count_reg == '0);
        stat.full  = (count_reg == CNT_W'(NUM_SLOTS));
        if (byp_reg)
        begin
            stat.pop_id = byp_data_reg;
        end
        else if (init_reg)
        begin
            stat.pop_id = {{(ID_W-SLOT_W){1'b0}}, head_reg};
        end
        else
        begin
            stat.pop_id = ram_q;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(NUM_SLOTS))
        else $error("free list count out of range");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> (count_reg != '0) && !ctrl.push)
        else $error("pop from empty free list or pop with push");
`endif

endmodule

FILE: design/gtia_slot_table.sv
// Descriptor slot table: stored id RAM, per-slot valid bits and write bypass.
module gtia_slot_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_issue,
    input  logic [gtia_pkg::SLOT_W-1:0]   rd_slot,
    input  gtia_pkg::gtia_slot_wr_t       wr,
    output logic [gtia_pkg::ID_W-1:0]     rd_id,
    output logic                          rd_valid
);
    import gtia_pkg::*;

    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [SLOT_W-1:0]    rd_slot_reg;
    logic                 byp_reg;
    logic [ID_W-1:0]      byp_data_reg;
    logic [ID_W-1:0]      ram_q;

    // Slot becomes valid on first write; an invalid slot reads with rd_valid low
    always_comb
    begin
        valid_next = valid_reg;
        if (wr.en)
        begin
            valid_next[wr.slot] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            byp_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_issue)
            begin
                byp_reg <= wr.en && (wr.slot == rd_slot);
            end
        end
    end

    // Read address and bypass data follow the read
    always_ff @(posedge clk)
    begin
        if (rd_issue)
        begin
            rd_slot_reg  <= rd_slot;
            byp_data_reg <= wr.id;
        end
    end

    gtia_ram #(
        .WIDTH (ID_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.slot),
        .wdata (wr.id),
        .re    (rd_issue),
        .raddr (rd_slot),
        .rdata (ram_q)
    );

    assign rd_id    = byp_reg ? byp_data_reg : ram_q;
    assign rd_valid = valid_reg[rd_slot_reg];

endmodule

FILE: design/generational_task_id_allocator_core.sv
// Top level of the generational task id allocator: request stage, compute and result register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------
//  request  | req_valid, req_stall | action, task_id
//  result   | res_valid, res_stall | status, result_id, slot
//
// One request per cycle sustained while the result is not stalled; each request gives one result.
// A request's result is registered through the request stage and the result register:
// taking the request captures it and issues the free list and slot table RAM
// reads; once the result register is free, the table update runs and the result register loads.
// No clearing pass after reset: requests are taken at once.
// A stalled result holds; a new request is still taken while the compute stage is free.
module generational_task_id_allocator_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [1:0]                    action,
    input  logic [gtia_pkg::TASK_W-1:0]   task_id,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [2:0]                    status,
    output logic [gtia_pkg::ID_W-1:0]     result_id,
    output logic [gtia_pkg::SLOT_W-1:0]   slot
);
    import gtia_pkg::*;

    logic              s1_valid_reg, s1_valid_next;
    logic [1:0]        act_reg;
    logic [TASK_W-1:0] id_reg;
    logic              req_fire, s1_fire, out_free;

    logic              res_valid_reg, res_valid_next;
    logic [2:0]        status_reg, status_next;
    logic [ID_W-1:0]   result_id_reg, result_id_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    gtia_fl_ctrl_t     fl_ctrl;
    gtia_fl_stat_t     fl_stat;
    gtia_slot_wr_t     slot_wr;
    logic [ID_W-1:0]   stored_id;
    logic              stored_valid;
    logic [SLOT_W-1:0] req_slot;

    // Handshake
    assign out_free  = !res_valid_reg || !res_stall;
    assign s1_fire   = s1_valid_reg && out_free;
    assign req_stall = s1_valid_reg && !out_free;
    assign req_fire  = req_valid && !req_stall;

    // Request stage
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            act_reg <= action;
            id_reg  <= task_id;
        end
    end

    gtia_free_list u_free_list (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_issue (req_fire),
        .ctrl     (fl_ctrl),
        .stat     (fl_stat)
    );

    gtia_slot_table u_slot_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_issue (req_fire),
        .rd_slot  (task_id[SLOT_W-1:0]),
        .wr       (slot_wr),
        .rd_id    (stored_id),
        .rd_valid (stored_valid)
    );

    // Compute: decode the action, update the tables, form the result
    assign req_slot = id_reg[SLOT_W-1:0];

    always_comb
    begin
        fl_ctrl        = '0;
        slot_wr        = '0;
        status_next    = ST_INVALID;
        result_id_next = '0;
        slot_next      = '0;
        case (act_reg)
            ACT_ALLOC:
            begin
                if (fl_stat.empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    status_next    = ST_OK;
                    result_id_next = fl_stat.pop_id;
                    slot_next      = fl_stat.pop_id[SLOT_W-1:0];
                    fl_ctrl.pop    = s1_fire;
                    slot_wr.en     = s1_fire;
                    slot_wr.slot   = fl_stat.pop_id[SLOT_W-1:0];
                    slot_wr.id     = fl_stat.pop_id;
                end
            end
            ACT_FREE:
            begin
                if (id_reg[TASK_W-1])
                begin
                    status_next = ST_INVALID;
                end
                else if (fl_stat.full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    // next generation; a never-used slot (taken as stored -1) gives N-1
                    status_next  = ST_OK;
                    slot_next    = req_slot;
                    fl_ctrl.push = s1_fire;
                    fl_ctrl.push_id = stored_valid ? stored_id + ID_W'(NUM_SLOTS)
                                                   : ID_W'(NUM_SLOTS - 1);
                end
            end
            ACT_GET:
            begin
                if (id_reg[TASK_W-1])
                begin
                    status_next = ST_INVALID;
                end
                else if (stored_valid && (stored_id == id_reg[ID_W-1:0]))
                begin
                    status_next    = ST_OK;
                    result_id_next = id_reg[ID_W-1:0];
                    slot_next      = req_slot;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            default:
            begin
                status_next = ST_INVALID;
            end
        endcase
    end

    // Result register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (s1_fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            status_reg    <= status_next;
            result_id_reg <= result_id_next;
            slot_reg      <= slot_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign status    = status_reg;
    assign result_id = result_id_reg;
    assign slot      = slot_reg;

`ifndef NO_ASSERTIONS
    a_stall_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> s1_valid_reg && res_valid_reg)
        else $error("request stalled while compute stage can move");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status != ST_OK) |-> (result_id == '0) && (slot == '0))
        else $error("failed result carries id or slot");

    a_slot_matches: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == ST_OK) && (result_id != '0)
            |-> slot == result_id[SLOT_W-1:0])
        else $error("result slot does not match result id");
`endif

endmodule
